FILE: hw/rtl/lmt_pkg.sv
// lmt_pkg: shared widths, constants, angle tables and pipeline types
// for the Web Mercator tile index pipeline. No dependencies.
`default_nettype none

package lmt_pkg;

    // field widths
    localparam int LON_W  = 29;
    localparam int LAT_W  = 28;
    localparam int ZOOM_W = 5;
    localparam int IDX_W  = 24;

    // largest zoom handled; one row-division step per zoom level
    localparam int ZOOM_CAP = 24;
    localparam int QW       = ZOOM_CAP + 1;

    // fixed point format, Q60
    localparam int FRAC       = 60;
    localparam int CIRC_ITERS = 60;
    localparam int HYP_ITERS  = 60;
    localparam int HYP_STAGES = HYP_ITERS + 3;   // 4, 13, 40 run twice
    localparam int NORM_STEPS = 8;
    localparam int TD_STEPS   = 28;              // quotient bits of the angle fraction
    localparam int TD_RW      = 57;
    localparam int BASE_W     = 62;

    localparam logic signed [63:0] PI_Q     = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] TWO_PI_Q = 64'sh6487ED5110B4611A;
    localparam logic signed [63:0] LN2_Q    = 64'sh0B17217F7D1CF79B;
    localparam logic signed [63:0] ONE_Q    = 64'sh1000000000000000;

    localparam logic [63:0] HALF_ANGLE_DIV = 64'd360000000;
    localparam logic [63:0] THETA_Q        = 64'(PI_Q) / HALF_ANGLE_DIV;
    localparam logic [63:0] THETA_R        = 64'(PI_Q) % HALF_ANGLE_DIV;
    localparam logic [16:0] THETA_QH       = THETA_Q[33:17];
    localparam logic [16:0] THETA_QL       = THETA_Q[16:0];
    localparam logic [28:0] THETA_RN       = THETA_R[28:0];

    localparam logic [LAT_W-1:0]      LAT_LIMIT  = 28'd85051129;
    localparam logic signed [LON_W:0] LON_OFFSET = 30'sd180000000;
    localparam logic [LON_W-1:0]      LON_SPAN   = 29'd360000000;

    // pipeline stage map
    localparam int S_TD0     = 3;
    localparam int S_T       = S_TD0 + TD_STEPS;
    localparam int S_C0      = S_T + 1;
    localparam int S_AB      = S_C0 + CIRC_ITERS - 1 + 1;
    localparam int S_N0      = S_AB + 1;
    localparam int S_H       = S_N0 + NORM_STEPS;
    localparam int S_Y0      = S_H + 1;
    localparam int S_M1      = S_Y0 + HYP_STAGES;
    localparam int S_M2      = S_M1 + 1;
    localparam int S_DI      = S_M2 + 1;
    localparam int OUT_STAGE = S_DI + 1 + ZOOM_CAP;
    localparam int LATENCY   = OUT_STAGE + 1;

    typedef logic signed [63:0] t_atab [0:CIRC_ITERS-1];
    typedef logic signed [63:0] t_htab [0:HYP_ITERS];
    typedef logic [5:0]         t_hidx [0:HYP_STAGES-1];

    typedef struct packed {
        logic signed [LON_W:0] lon_v;
        logic [ZOOM_W-1:0]     zoom;
        logic                  lat_neg;
        logic                  polar;
        logic                  zero;
    } t_side;

    typedef struct packed {
        logic [TD_RW-1:0]    rem;
        logic [TD_STEPS-1:0] q;
        logic [BASE_W-1:0]   base;
    } t_tdiv;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_circ;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [3:0]         e;
        logic               bad;
    } t_norm;

    typedef struct packed {
        logic signed [63:0] hx;
        logic signed [63:0] hy;
        logic signed [63:0] hz;
        logic [3:0]         e;
        logic               bad;
    } t_hyp;

    typedef struct packed {
        logic [63:0]   rem;
        logic [QW-1:0] q;
        logic          lo;   // force index to zero
        logic          hi;   // force index to last tile
    } t_div;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // truncated series for atan / atanh of 2^-i, floored terms
    function automatic logic signed [63:0] f_series(input int i, input logic alt);
        logic signed [63:0] s;
        logic signed [63:0] t;
        int e;
        s = '0;
        for (int k = 0; k <= 30; k++) begin
            e = FRAC - i * (2 * k + 1);
            if (e >= 0) begin
                t = $signed(f_udiv(64'd1 << e, 64'(2 * k + 1)));
                s = (alt && k[0]) ? s - t : s + t;
            end
        end
        return s;
    endfunction

    function automatic t_atab f_atan_tab();
        t_atab t;
        t[0] = PI_Q >>> 2;
        for (int i = 1; i < CIRC_ITERS; i++) begin
            t[i] = f_series(i, 1'b1);
        end
        return t;
    endfunction

    function automatic t_htab f_atanh_tab();
        t_htab t;
        t[0] = '0;
        for (int i = 1; i <= HYP_ITERS; i++) begin
            t[i] = f_series(i, 1'b0);
        end
        return t;
    endfunction

    function automatic t_hidx f_hyp_idx();
        t_hidx t;
        int n;
        n = 0;
        for (int i = 1; i <= HYP_ITERS; i++) begin
            t[n] = 6'(i);
            n++;
            if (i == 4 || i == 13 || i == 40) begin
                t[n] = 6'(i);
                n++;
            end
        end
        return t;
    endfunction

    localparam t_atab ATAN_TAB  = f_atan_tab();
    localparam t_htab ATANH_TAB = f_atanh_tab();
    localparam t_hidx HYP_IDX   = f_hyp_idx();

endpackage

`default_nettype wire

FILE: hw/rtl/lmt_tdiv_cell.sv
// lmt_tdiv_cell: one quotient bit of the latitude-to-angle constant division.
// Depends on lmt_pkg.
`default_nettype none

module lmt_tdiv_cell (
    input  logic                       i_clk,
    input  logic [lmt_pkg::TD_RW-1:0]  i_dsh,
    input  lmt_pkg::t_tdiv             i_p,
    output lmt_pkg::t_tdiv             o_p
);
    import lmt_pkg::*;

    t_tdiv r_p;
    t_tdiv n_p;
    logic  ge;

    always_comb begin
        ge      = (i_p.rem >= i_dsh);
        n_p     = i_p;
        n_p.rem = ge ? i_p.rem - i_dsh : i_p.rem;
        n_p.q   = {i_p.q[TD_STEPS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/lmt_circ_cell.sv
// lmt_circ_cell: one rotation of the circular CORDIC (tan of the half angle).
// Depends on lmt_pkg.
`default_nettype none

module lmt_circ_cell (
    input  logic               i_clk,
    input  logic [5:0]         i_sh,
    input  logic signed [63:0] i_ang,
    input  lmt_pkg::t_circ     i_p,
    output lmt_pkg::t_circ     o_p
);
    import lmt_pkg::*;

    t_circ              r_p;
    t_circ              n_p;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] dx;
    logic signed [63:0] dy;

    always_comb begin
        x  = i_p.x;
        y  = i_p.y;
        dx = y >>> i_sh;
        dy = x >>> i_sh;
        n_p = i_p;
        if (!i_p.z[63]) begin
            n_p.x = x - dx;
            n_p.y = y + dy;
            n_p.z = i_p.z - i_ang;
        end else begin
            n_p.x = x + dx;
            n_p.y = y - dy;
            n_p.z = i_p.z + i_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/lmt_norm_cell.sv
// lmt_norm_cell: one doubling step bringing b within a factor two of a.
// Depends on lmt_pkg.
`default_nettype none

module lmt_norm_cell (
    input  logic           i_clk,
    input  lmt_pkg::t_norm i_p,
    output lmt_pkg::t_norm o_p
);
    import lmt_pkg::*;

    t_norm              r_p;
    t_norm              n_p;
    logic signed [64:0] a2;
    logic signed [64:0] b2;

    always_comb begin
        a2  = {i_p.a[63], i_p.a};
        b2  = {i_p.b, 1'b0};
        n_p = i_p;
        if (a2 >= b2) begin
            n_p.b = b2[63:0];
            n_p.e = i_p.e + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/lmt_hyp_cell.sv
// lmt_hyp_cell: one hyperbolic vectoring CORDIC iteration (atanh accumulate).
// Depends on lmt_pkg.
`default_nettype none

module lmt_hyp_cell (
    input  logic               i_clk,
    input  logic [5:0]         i_sh,
    input  logic signed [63:0] i_ang,
    input  lmt_pkg::t_hyp      i_p,
    output lmt_pkg::t_hyp      o_p
);
    import lmt_pkg::*;

    t_hyp               r_p;
    t_hyp               n_p;
    logic signed [63:0] hx;
    logic signed [63:0] hy;
    logic signed [63:0] dx;
    logic signed [63:0] dy;

    always_comb begin
        hx  = i_p.hx;
        hy  = i_p.hy;
        dx  = hy >>> i_sh;
        dy  = hx >>> i_sh;
        n_p = i_p;
        n_p.hx = hx - dx;
        if (!hy[63]) begin
            n_p.hy = hy - dy;
            n_p.hz = i_p.hz + i_ang;
        end else begin
            n_p.hy = hy + dy;
            n_p.hz = i_p.hz - i_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/lmt_div_cell.sv
// lmt_div_cell: one step of floor(n * 2^z / d); passes through past the zoom.
// Depends on lmt_pkg.
`default_nettype none

module lmt_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_d,
    input  lmt_pkg::t_div i_p,
    output lmt_pkg::t_div o_p
);
    import lmt_pkg::*;

    t_div        r_p;
    t_div        n_p;
    logic [64:0] r2;
    logic [64:0] rs;
    logic        ge;

    always_comb begin
        r2  = {i_p.rem, 1'b0};
        ge  = (r2 >= {1'b0, i_d});
        rs  = r2 - {1'b0, i_d};
        n_p = i_p;
        if (i_en) begin
            n_p.rem = ge ? rs[63:0] : r2[63:0];
            n_p.q   = {i_p.q[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/lonlat_to_mercator_tile.sv
// lonlat_to_mercator_tile: top level, longitude/latitude to slippy-map tile.
// Depends on lmt_pkg and the lmt_*_cell modules.
`default_nettype none

// Converts one coordinate per clock into a Web Mercator tile column and row.
// Pulse start with the longitude, latitude (signed microdegrees) and zoom; busy
// is never raised, so a request can be issued every cycle. Each request gives
// exactly one result, shown for one cycle with o_strobe high; the receiver
// cannot stall it. The chain holds 28 angle-division cells, 60 circular
// CORDIC cells, 8 normalizing cells, 63 hyperbolic CORDIC cells and 24
// division cells per axis (one per zoom level), with registers around them.
// Zoom above 24 is treated as 24. o_clamped marks an index that was forced
// into 0..2^zoom-1 (longitude below -180 or at or past 180, latitude beyond
// about 85.05).

module lonlat_to_mercator_tile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lmt_pkg::LON_W-1:0]    i_lon_microdeg,
    input  logic signed [lmt_pkg::LAT_W-1:0]    i_lat_microdeg,
    input  logic [lmt_pkg::ZOOM_W-1:0]          i_zoom,
    output logic                                o_strobe,
    output logic [lmt_pkg::IDX_W-1:0]           o_tile_x,
    output logic [lmt_pkg::IDX_W-1:0]           o_tile_y,
    output logic                                o_clamped
);
    import lmt_pkg::*;

    // valid and sideband shift lines running beside the cells
    logic  r_vld  [0:OUT_STAGE];
    t_side r_side [0:OUT_STAGE-1];
    t_side n_side;

    logic              accept;
    logic [LAT_W-1:0]  mag;
    logic [LAT_W-1:0]  r_mag;

    // stage 1: partial products of the angle scaling
    logic [44:0] r_p_hi;
    logic [44:0] r_p_lo;
    logic [56:0] r_p_r;

    t_tdiv w_td [0:TD_STEPS];
    t_circ w_cc [0:CIRC_ITERS];
    t_norm w_nm [0:NORM_STEPS];
    t_hyp  w_hy [0:HYP_STAGES];
    t_div  w_dx [0:ZOOM_CAP];
    t_div  w_dy [0:ZOOM_CAP];

    t_tdiv r_tdi;
    t_circ r_cci;
    t_norm r_nmi;
    t_hyp  r_hyi;
    t_div  r_dxi;
    t_div  r_dyi;

    logic signed [63:0] r_merc;
    logic               r_m1_bad;
    logic signed [63:0] r_num;
    logic               r_m2_bad;

    logic [IDX_W-1:0] r_tile_x;
    logic [IDX_W-1:0] r_tile_y;
    logic             r_clamped;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // request capture: magnitude, pole and zero tests, offset longitude, zoom cap
    always_comb begin
        mag            = i_lat_microdeg[LAT_W-1] ? LAT_W'(-i_lat_microdeg)
                                                 : LAT_W'(i_lat_microdeg);
        n_side.lon_v   = $signed({i_lon_microdeg[LON_W-1], i_lon_microdeg}) + LON_OFFSET;
        n_side.zoom    = (i_zoom > ZOOM_W'(ZOOM_CAP)) ? ZOOM_W'(ZOOM_CAP) : i_zoom;
        n_side.lat_neg = i_lat_microdeg[LAT_W-1];
        n_side.polar   = (mag >= LAT_LIMIT);
        n_side.zero    = (mag == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= accept;
        end
    end

    generate
        for (genvar k = 1; k <= OUT_STAGE; k++) begin : g_vld
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
        for (genvar k = 1; k < OUT_STAGE; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                r_side[k] <= r_side[k-1];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        r_mag     <= mag;
    end

    // theta = floor(m * pi_q / 360e6) = m*Q + floor(m*R / 360e6)
    always_ff @(posedge i_clk) begin
        r_p_hi <= 45'(r_mag) * 45'(THETA_QH);
        r_p_lo <= 45'(r_mag) * 45'(THETA_QL);
        r_p_r  <= 57'(r_mag) * 57'(THETA_RN);
    end

    always_ff @(posedge i_clk) begin
        r_tdi.rem  <= r_p_r;
        r_tdi.q    <= '0;
        r_tdi.base <= (BASE_W'(r_p_hi) << 17) + BASE_W'(r_p_lo);
    end

    assign w_td[0] = r_tdi;

    generate
        for (genvar j = 0; j < TD_STEPS; j++) begin : g_td
            lmt_tdiv_cell u_cell (
                .i_clk (i_clk),
                .i_dsh (TD_RW'(HALF_ANGLE_DIV) << (TD_STEPS - 1 - j)),
                .i_p   (w_td[j]),
                .o_p   (w_td[j+1])
            );
        end
    endgenerate

    // circular CORDIC from unit x, no gain correction
    always_ff @(posedge i_clk) begin
        r_cci.x <= ONE_Q;
        r_cci.y <= '0;
        r_cci.z <= $signed(64'(w_td[TD_STEPS].base) + 64'(w_td[TD_STEPS].q));
    end

    assign w_cc[0] = r_cci;

    generate
        for (genvar j = 0; j < CIRC_ITERS; j++) begin : g_cc
            lmt_circ_cell u_cell (
                .i_clk (i_clk),
                .i_sh  (6'(j)),
                .i_ang (ATAN_TAB[j]),
                .i_p   (w_cc[j]),
                .o_p   (w_cc[j+1])
            );
        end
    endgenerate

    // merc = ln((x+y)/(x-y)); a nonpositive term makes the row unusable
    always_ff @(posedge i_clk) begin
        r_nmi.a   <= w_cc[CIRC_ITERS].x + w_cc[CIRC_ITERS].y;
        r_nmi.b   <= w_cc[CIRC_ITERS].x - w_cc[CIRC_ITERS].y;
        r_nmi.e   <= '0;
        r_nmi.bad <= ((w_cc[CIRC_ITERS].x - w_cc[CIRC_ITERS].y) <= 64'sd0) ||
                     ((w_cc[CIRC_ITERS].x + w_cc[CIRC_ITERS].y) <= 64'sd0);
    end

    assign w_nm[0] = r_nmi;

    generate
        for (genvar j = 0; j < NORM_STEPS; j++) begin : g_nm
            lmt_norm_cell u_cell (
                .i_clk (i_clk),
                .i_p   (w_nm[j]),
                .o_p   (w_nm[j+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_hyi.hx  <= w_nm[NORM_STEPS].a + w_nm[NORM_STEPS].b;
        r_hyi.hy  <= w_nm[NORM_STEPS].a - w_nm[NORM_STEPS].b;
        r_hyi.hz  <= '0;
        r_hyi.e   <= w_nm[NORM_STEPS].e;
        r_hyi.bad <= w_nm[NORM_STEPS].bad;
    end

    assign w_hy[0] = r_hyi;

    generate
        for (genvar j = 0; j < HYP_STAGES; j++) begin : g_hy
            lmt_hyp_cell u_cell (
                .i_clk (i_clk),
                .i_sh  (HYP_IDX[j]),
                .i_ang (ATANH_TAB[HYP_IDX[j]]),
                .i_p   (w_hy[j]),
                .o_p   (w_hy[j+1])
            );
        end
    endgenerate

    // merc = e*ln2 + 2*atanh
    always_ff @(posedge i_clk) begin
        r_merc   <= $signed(64'(w_hy[HYP_STAGES].e) * 64'(LN2_Q)) +
                    (w_hy[HYP_STAGES].hz <<< 1);
        r_m1_bad <= w_hy[HYP_STAGES].bad;
    end

    // numerator pi - merc, merc mirrored for southern latitudes
    always_ff @(posedge i_clk) begin
        if (r_side[S_M1].zero) begin
            r_num <= PI_Q;
        end else if (r_side[S_M1].lat_neg) begin
            r_num <= PI_Q + r_merc;
        end else begin
            r_num <= PI_Q - r_merc;
        end
        r_m2_bad <= r_m1_bad;
    end

    // division set-up: integer quotient is 0 or 1 on both axes
    logic        lat_over;
    logic        num_neg;
    logic        num_ge;
    logic        lon_ge;
    t_side       s_m2;

    always_comb begin
        s_m2     = r_side[S_M2];
        lat_over = s_m2.polar || (r_m2_bad && !s_m2.zero);
        num_neg  = r_num[63];
        num_ge   = !num_neg && (64'(r_num) >= 64'(TWO_PI_Q));
        lon_ge   = !s_m2.lon_v[LON_W] && (s_m2.lon_v[LON_W-1:0] >= LON_SPAN);
    end

    always_ff @(posedge i_clk) begin
        r_dyi.rem <= num_ge ? 64'(r_num) - 64'(TWO_PI_Q) : 64'(r_num);
        r_dyi.q   <= QW'(num_ge);
        r_dyi.hi  <= lat_over && s_m2.lat_neg;
        r_dyi.lo  <= (lat_over && !s_m2.lat_neg) || (!lat_over && num_neg);
        r_dxi.rem <= lon_ge ? 64'(s_m2.lon_v[LON_W-1:0] - LON_SPAN)
                            : 64'(s_m2.lon_v[LON_W-1:0]);
        r_dxi.q   <= QW'(lon_ge);
        r_dxi.hi  <= 1'b0;
        r_dxi.lo  <= s_m2.lon_v[LON_W];
    end

    assign w_dx[0] = r_dxi;
    assign w_dy[0] = r_dyi;

    // one quotient bit per zoom level, cells beyond the zoom pass through
    generate
        for (genvar j = 0; j < ZOOM_CAP; j++) begin : g_dv
            logic en;
            assign en = (ZOOM_W'(j) < r_side[S_DI + j].zoom);
            lmt_div_cell u_dx (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (64'(LON_SPAN)),
                .i_p   (w_dx[j]),
                .o_p   (w_dx[j+1])
            );
            lmt_div_cell u_dy (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (64'(TWO_PI_Q)),
                .i_p   (w_dy[j]),
                .o_p   (w_dy[j+1])
            );
        end
    endgenerate

    // clamp into 0..2^zoom-1
    logic [QW-1:0] maxidx;
    logic [QW-1:0] tx;
    logic [QW-1:0] ty;
    logic          x_over;
    logic          y_over;
    t_div          dx_f;
    t_div          dy_f;

    always_comb begin
        dx_f   = w_dx[ZOOM_CAP];
        dy_f   = w_dy[ZOOM_CAP];
        maxidx = (QW'(1) << r_side[OUT_STAGE-1].zoom) - QW'(1);
        x_over = dx_f.q > maxidx;
        y_over = dy_f.q > maxidx;
        if (dx_f.hi) begin
            tx = maxidx;
        end else if (dx_f.lo) begin
            tx = '0;
        end else begin
            tx = x_over ? maxidx : dx_f.q;
        end
        if (dy_f.hi) begin
            ty = maxidx;
        end else if (dy_f.lo) begin
            ty = '0;
        end else begin
            ty = y_over ? maxidx : dy_f.q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tile_x  <= tx[IDX_W-1:0];
        r_tile_y  <= ty[IDX_W-1:0];
        r_clamped <= dx_f.hi || dx_f.lo || x_over || dy_f.hi || dy_f.lo || y_over;
    end

    assign o_strobe  = r_vld[OUT_STAGE];
    assign o_tile_x  = r_tile_x;
    assign o_tile_y  = r_tile_y;
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

FILE: hw/rtl/lmt_checker.sv
// lmt_checker: port-level checks of the tile index pipeline, bound to the top.
// Depends on lmt_pkg and lonlat_to_mercator_tile.
`default_nettype none

module lmt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic signed [lmt_pkg::LON_W-1:0] i_lon_microdeg,
    input logic signed [lmt_pkg::LAT_W-1:0] i_lat_microdeg,
    input logic [lmt_pkg::ZOOM_W-1:0]       i_zoom,
    input logic                             o_strobe,
    input logic [lmt_pkg::IDX_W-1:0]        o_tile_x,
    input logic [lmt_pkg::IDX_W-1:0]        o_tile_y,
    input logic                             o_clamped
);
    import lmt_pkg::*;

    // every request comes back after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result missing after request");

    // no result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // west edge maps to column zero
    a_west_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_lon_microdeg == -29'sd180000000) |->
            ##LATENCY (o_strobe && o_tile_x == '0))
        else $error("west edge not column zero");

    // far north is clamped to the top row
    a_north_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_lat_microdeg >= $signed({1'b0, LAT_LIMIT[LAT_W-2:0]})) |->
            ##LATENCY (o_strobe && o_clamped && o_tile_y == '0))
        else $error("polar north not clamped to row zero");

endmodule

bind lonlat_to_mercator_tile lmt_checker u_lmt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_lon_microdeg (i_lon_microdeg),
    .i_lat_microdeg (i_lat_microdeg),
    .i_zoom         (i_zoom),
    .o_strobe       (o_strobe),
    .o_tile_x       (o_tile_x),
    .o_tile_y       (o_tile_y),
    .o_clamped      (o_clamped)
);

`default_nettype wire

FILE: test/tile_index_checker.sv
// tile_index_checker: watches requests and results of lonlat_to_mercator_tile,
// predicts each tile index in Q60 fixed point and compares. Depends on lmt_pkg.
`timescale 1ns / 1ps

module tile_index_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic signed [lmt_pkg::LON_W-1:0] i_lon_microdeg,
    input  logic signed [lmt_pkg::LAT_W-1:0] i_lat_microdeg,
    input  logic [lmt_pkg::ZOOM_W-1:0]       i_zoom,
    input  logic                             o_strobe,
    input  logic [lmt_pkg::IDX_W-1:0]        o_tile_x,
    input  logic [lmt_pkg::IDX_W-1:0]        o_tile_y,
    input  logic                             o_clamped,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lmt_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] tx;
        logic [IDX_W-1:0] ty;
        logic             clamped;
    } t_tile;

    localparam longint PI_L  = 64'sh3243F6A8885A308D;
    localparam longint LN2_L = 64'sh0B17217F7D1CF79B;
    localparam longint ONE_L = 64'sh1000000000000000;
    localparam longint DIV_L = 360000000;
    localparam longint POLAR = 85051129;

    longint circ_angle [0:59];
    longint hyp_angle  [0:60];
    t_tile  tile_q [$];
    int     fails;

    assign o_fail_count = fails;
    assign o_pending    = tile_q.size();

    // floored power series for atan / atanh of 2^-i
    function automatic longint angle_series(int i, bit alternate);
        longint sum;
        longint t;
        int     e;
        sum = 0;
        for (int k = 0; ; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e < 0) break;
            t = longint'((64'd1 << e) / 64'(2 * k + 1));
            sum = (alternate && k[0]) ? sum - t : sum + t;
        end
        return sum;
    endfunction

    initial begin
        circ_angle[0] = PI_L >>> 2;
        for (int i = 1; i < 60; i++) circ_angle[i] = angle_series(i, 1'b1);
        hyp_angle[0] = 0;
        for (int i = 1; i <= 60; i++) hyp_angle[i] = angle_series(i, 1'b0);
    end

    // asinh(tan(m)) in Q60 for 0 < m < polar limit; returns 0 if unusable
    function automatic bit mercator_of(longint m, output longint merc);
        longint x, y, z, a, b, hx, hy, hz, dx, dy;
        int     e, reps;
        z = m * (PI_L / DIV_L) + (m * (PI_L % DIV_L)) / DIV_L;
        x = ONE_L;
        y = 0;
        hz = 0;
        e = 0;
        merc = 0;
        for (int i = 0; i < 60; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= circ_angle[i];
            end else begin
                x += dx; y -= dy; z += circ_angle[i];
            end
        end
        a = x + y;
        b = x - y;
        if (b <= 0 || a <= 0) return 1'b0;
        while (e < 8 && a >= 2 * b) begin
            b *= 2;
            e++;
        end
        hx = a + b;
        hy = a - b;
        for (int i = 1; i <= 60; i++) begin
            reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
            for (int r = 0; r < reps; r++) begin
                dx = hy >>> i;
                dy = hx >>> i;
                if (hy >= 0) begin
                    hx -= dx; hy -= dy; hz += hyp_angle[i];
                end else begin
                    hx -= dx; hy += dy; hz -= hyp_angle[i];
                end
            end
        end
        merc = longint'(e) * LN2_L + 2 * hz;
        return 1'b1;
    endfunction

    function automatic t_tile predict_tile(logic signed [LON_W-1:0] lon,
                                           logic signed [LAT_W-1:0] lat,
                                           logic [ZOOM_W-1:0] zoom);
        t_tile       res;
        int          z;
        logic [63:0] maxidx, tx, ty, n, d, q, r;
        longint      v, mag, merc, num;
        bit          flag, ok;
        z = (zoom > ZOOM_CAP) ? ZOOM_CAP : int'(zoom);
        maxidx = (64'd1 << z) - 1;
        flag = 1'b0;

        v = longint'(lon) + 180000000;
        if (v < 0) begin
            tx = 0; flag = 1'b1;
        end else begin
            tx = (64'(v) << z) / 64'd360000000;
            if (tx > maxidx) begin
                tx = maxidx; flag = 1'b1;
            end
        end

        mag = (lat < 0) ? -longint'(lat) : longint'(lat);
        merc = 0;
        ok = 1'b1;
        if (mag != 0 && mag < POLAR) ok = mercator_of(mag, merc);
        if (mag >= POLAR || !ok) begin
            ty = (lat > 0) ? 0 : maxidx;
            flag = 1'b1;
        end else begin
            if (lat < 0) merc = -merc;
            num = PI_L - merc;
            if (num < 0) begin
                ty = 0; flag = 1'b1;
            end else begin
                // exact floor(num * 2^z / (2 pi)) by long division
                n = 64'(num);
                d = 64'(2 * PI_L);
                q = n / d;
                r = n % d;
                for (int i = 0; i < z; i++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= d) begin
                        r -= d; q[0] = 1'b1;
                    end
                end
                ty = q;
                if (ty > maxidx) begin
                    ty = maxidx; flag = 1'b1;
                end
            end
        end
        res.tx = tx[IDX_W-1:0];
        res.ty = ty[IDX_W-1:0];
        res.clamped = flag;
        return res;
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        t_tile want;
        if (i_rst_n) begin
            if (start && !busy)
                tile_q.push_back(predict_tile(i_lon_microdeg, i_lat_microdeg, i_zoom));
            if (o_strobe) begin
                if (tile_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result x=%0d y=%0d c=%0b",
                                 o_tile_x, o_tile_y, o_clamped);
                end else begin
                    want = tile_q.pop_front();
                    if (want.tx !== o_tile_x || want.ty !== o_tile_y ||
                        want.clamped !== o_clamped) begin
                        fails++;
                        if (fails <= 10)
                            $display("tile mismatch: want x=%0d y=%0d c=%0b, got x=%0d y=%0d c=%0b",
                                     want.tx, want.ty, want.clamped,
                                     o_tile_x, o_tile_y, o_clamped);
                    end
                end
            end
        end
    end

endmodule

FILE: test/testbench.sv
// testbench: drives coordinate requests into lonlat_to_mercator_tile and gives
// the verdict. Depends on lmt_pkg, the block and tile_index_checker.
`timescale 1ns / 1ps

module testbench;
    import lmt_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [LON_W-1:0]   i_lon_microdeg;
    logic signed [LAT_W-1:0]   i_lat_microdeg;
    logic [ZOOM_W-1:0]         i_zoom;
    logic                      o_strobe;
    logic [IDX_W-1:0]          o_tile_x;
    logic [IDX_W-1:0]          o_tile_y;
    logic                      o_clamped;
    int                        fail_count;
    int                        pending;

    localparam int LAT_EDGE = 85051129;

    lonlat_to_mercator_tile dut (.*);

    tile_index_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_lon_microdeg, .i_lat_microdeg, .i_zoom,
        .o_strobe, .o_tile_x, .o_tile_y, .o_clamped,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // one request; start stays high while the next request follows back to back
    task automatic send_request(int lon, int lat, int zoom, int gap);
        i_lon_microdeg <= LON_W'(lon);
        i_lat_microdeg <= LAT_W'(lat);
        i_zoom         <= ZOOM_W'(zoom);
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int random_lat();
        case ($urandom_range(0, 9))
            0:       return $signed(LAT_W'($urandom));          // whole field
            1:       return LAT_EDGE - 3 + $urandom_range(0, 6); // near polar edge
            2:       return -LAT_EDGE - 3 + $urandom_range(0, 6);
            3:       return $urandom_range(0, 2000) - 1000;      // around equator
            default: return int'($urandom_range(0, 170000000)) - 85000000;
        endcase
    endfunction

    function automatic int random_lon();
        case ($urandom_range(0, 9))
            0:       return $signed(LON_W'($urandom));
            1:       return 180000000 - 2 + $urandom_range(0, 4);
            2:       return -180000000 - 2 + $urandom_range(0, 4);
            default: return int'($urandom_range(0, 360000000)) - 180000000;
        endcase
    endfunction

    initial begin
        int burst;
        start          <= 1'b0;
        i_lon_microdeg <= '0;
        i_lat_microdeg <= '0;
        i_zoom         <= '0;
        i_rst_n        <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, date line, equator, polar edge, zoom saturation
        send_request(-180000000, 0, 0, 0);
        send_request(180000000, 0, 24, 1);
        send_request(-(1 << 28), -(1 << 27), 31, 0);
        send_request((1 << 28) - 1, (1 << 27) - 1, 25, 2);
        send_request(-180000001, LAT_EDGE, 24, 0);
        send_request(179999999, -LAT_EDGE, 24, 0);
        send_request(0, LAT_EDGE - 1, 24, 3);
        send_request(0, -(LAT_EDGE - 1), 24, 0);
        send_request(0, 90000000, 10, 0);
        send_request(0, -90000000, 10, 0);
        send_request(1, 1, 24, 0);
        send_request(-1, -1, 24, 0);
        send_request(123456789, 45000000, 16, 5);
        send_request(-123456789, -45000000, 1, 0);
        send_request(0, 0, 24, 0);
        send_request(0, 0, 0, 0);

        // random, mostly in range; runs of back-to-back requests between gaps
        burst = 0;
        for (int i = 0; i < 400; i++) begin
            if (i == 200) begin
                // drain the pipe completely before carrying on
                start <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            if (burst == 0 && $urandom_range(0, 7) == 0) burst = $urandom_range(5, 30);
            send_request(random_lon(), random_lat(), $urandom_range(0, 31),
                         burst > 0 ? 0 : $urandom_range(0, 14));
            if (burst > 0) burst--;
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: lonlat_to_mercator_tile.f
hw/rtl/lmt_pkg.sv
hw/rtl/lmt_tdiv_cell.sv
hw/rtl/lmt_circ_cell.sv
hw/rtl/lmt_norm_cell.sv
hw/rtl/lmt_hyp_cell.sv
hw/rtl/lmt_div_cell.sv
hw/rtl/lonlat_to_mercator_tile.sv
hw/rtl/lmt_checker.sv
test/tile_index_checker.sv
test/testbench.sv
